/* design/irt_pkg.sv */
package irt_pkg;

   localparam int ROW_W = 16;
   localparam int SEAT_W = 20;
   localparam int OWNER_W = 16;
   localparam int STATUS_W = 3;

   localparam int DEF_ENTRIES = 256;
   localparam int DEF_ROWS = 65536;
   localparam int DEF_SEAT_BITS = 20;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_RESERVE = 1'b0,
      CMD_LOOKUP  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_RESERVED = 3'd0,
      ST_OVERLAP  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NONE     = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [ROW_W-1:0]    row;
      logic [SEAT_W-1:0]   first;
      logic [SEAT_W-1:0]   last;
      logic [SEAT_W-1:0]   seat;
      logic [OWNER_W-1:0]  owner;
      logic                row_ok;
   } item_type;

   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [SEAT_W-1:0]   first;
      logic [SEAT_W-1:0]   last;
      logic [OWNER_W-1:0]  owner;
   } entry_type;

   function automatic logic [SEAT_W-1:0] seat_mask(input int bits);
      logic [SEAT_W-1:0] m;
      for (int i = 0; i < SEAT_W; i++) begin
         m[i] = (i < bits);
      end
      return m;
   endfunction

endpackage

/* design/irt_front.sv */
module irt_front #(
   parameter int ROWS = irt_pkg::DEF_ROWS,
   parameter int SEAT_BITS = irt_pkg::DEF_SEAT_BITS
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [irt_pkg::ROW_W-1:0]    req_row,
   input  logic [irt_pkg::SEAT_W-1:0]   req_first_seat,
   input  logic [irt_pkg::SEAT_W-1:0]   req_last_seat,
   input  logic [irt_pkg::SEAT_W-1:0]   req_lookup_seat,
   input  logic [irt_pkg::OWNER_W-1:0]  req_owner_id,
   output logic                         push,
   output irt_pkg::item_type            push_item,
   input  logic                         queue_full
);

   localparam logic [irt_pkg::SEAT_W-1:0] SEAT_MASK = irt_pkg::seat_mask(SEAT_BITS);
   localparam logic [31:0] ROW_LIMIT = 32'(ROWS);

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   always_comb begin
      push_item.cmd    = irt_pkg::cmd_type'(req_command);
      push_item.row    = req_row;
      push_item.first  = req_first_seat & SEAT_MASK;
      push_item.last   = req_last_seat & SEAT_MASK;
      push_item.seat   = req_lookup_seat & SEAT_MASK;
      push_item.owner  = req_owner_id;
      push_item.row_ok = (32'(req_row) < ROW_LIMIT);
   end

endmodule

/* design/irt_queue.sv */
module irt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  irt_pkg::item_type  push_item,
   output logic               full,
   output logic               pop_valid,
   output irt_pkg::item_type  pop_item,
   input  logic               pop
);

   localparam int PTR_W = (irt_pkg::QUEUE_DEPTH > 1) ? $clog2(irt_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(irt_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(irt_pkg::QUEUE_DEPTH - 1);

   irt_pkg::item_type slot_ff [irt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(irt_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/irt_back.sv */
module irt_back #(
   parameter int ENTRIES = irt_pkg::DEF_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   input  irt_pkg::item_type             pop_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [irt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [irt_pkg::OWNER_W-1:0]   rsp_found_owner
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   irt_pkg::entry_type entry_mem_ff [ENTRIES];
   irt_pkg::entry_type rd_data_ff;

   irt_pkg::item_type cur_ff, cur_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic chk_vld_ff, chk_vld_in;
   irt_pkg::status_type res_status_ff, res_status_in;
   logic [irt_pkg::OWNER_W-1:0] res_owner_ff, res_owner_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [irt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [irt_pkg::OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;

   logic rd_en;
   logic wr_en;
   logic hit;
   logic out_free;
   irt_pkg::entry_type wr_data;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_owner = rsp_owner_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      hit = 1'b0;
      if (chk_vld_ff && rd_data_ff.row == cur_ff.row) begin
         if (cur_ff.cmd == irt_pkg::CMD_RESERVE) begin
            hit = !(rd_data_ff.last < cur_ff.first || cur_ff.last < rd_data_ff.first);
         end else begin
            hit = (rd_data_ff.first <= cur_ff.seat) && (cur_ff.seat <= rd_data_ff.last);
         end
      end
   end

   always_comb begin
      wr_data.row = cur_ff.row;
      wr_data.first = cur_ff.first;
      wr_data.last = cur_ff.last;
      wr_data.owner = cur_ff.owner;
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      addr_in = addr_ff;
      count_in = count_ff;
      chk_vld_in = 1'b0;
      res_status_in = res_status_ff;
      res_owner_in = res_owner_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in = rsp_owner_ff;
      pop = 1'b0;
      rd_en = 1'b0;
      wr_en = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop = 1'b1;
               cur_in = pop_item;
               addr_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!cur_ff.row_ok) begin
               if (cur_ff.cmd == irt_pkg::CMD_RESERVE) begin
                  res_status_in = irt_pkg::ST_OVERLAP;
               end else begin
                  res_status_in = irt_pkg::ST_NONE;
               end
               res_owner_in = '0;
               state_in = S_DONE;
            end else if (hit) begin
               if (cur_ff.cmd == irt_pkg::CMD_RESERVE) begin
                  res_status_in = irt_pkg::ST_OVERLAP;
                  res_owner_in = '0;
               end else begin
                  res_status_in = irt_pkg::ST_FOUND;
                  res_owner_in = rd_data_ff.owner;
               end
               state_in = S_DONE;
            end else if (addr_ff < count_ff) begin
               rd_en = 1'b1;
               chk_vld_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end else begin
               res_owner_in = '0;
               if (cur_ff.cmd == irt_pkg::CMD_LOOKUP) begin
                  res_status_in = irt_pkg::ST_NONE;
               end else if (count_ff == FULL_COUNT) begin
                  res_status_in = irt_pkg::ST_FULL;
               end else begin
                  res_status_in = irt_pkg::ST_RESERVED;
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_owner_in = res_owner_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         chk_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         chk_vld_ff <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      addr_ff <= addr_in;
      res_status_ff <= res_status_in;
      res_owner_ff <= res_owner_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff <= rsp_owner_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[addr_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         entry_mem_ff[count_ff[IDX_W-1:0]] <= wr_data;
      end
   end

endmodule

/* design/interval_reservation_table.sv */
// Seat reservation table shared by all rows. Requests enter a two-deep queue and
// are served one at a time by a scan engine that reads the entry memory at one
// address per cycle through the stored entries (a lookup or an overlapping
// reserve stops at the first match). A reserve appends its range when no
// stored range on the row overlaps, else answers overlap; a full table with no
// overlap answers full. A lookup returns the owner of the lowest stored entry
// on the row that contains the seat. Rows at or above ROWS hold nothing.
// No clearing pass follows reset.
module interval_reservation_table #(
   parameter int ENTRIES = irt_pkg::DEF_ENTRIES,
   parameter int ROWS = irt_pkg::DEF_ROWS,
   parameter int SEAT_BITS = irt_pkg::DEF_SEAT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [irt_pkg::ROW_W-1:0]     req_row,
   input  logic [irt_pkg::SEAT_W-1:0]    req_first_seat,
   input  logic [irt_pkg::SEAT_W-1:0]    req_last_seat,
   input  logic [irt_pkg::SEAT_W-1:0]    req_lookup_seat,
   input  logic [irt_pkg::OWNER_W-1:0]   req_owner_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [irt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [irt_pkg::OWNER_W-1:0]   rsp_found_owner
);

   logic push;
   irt_pkg::item_type push_item;
   logic queue_full;
   logic pop_valid;
   irt_pkg::item_type pop_item;
   logic pop;

   irt_front #(
      .ROWS      (ROWS),
      .SEAT_BITS (SEAT_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_row         (req_row),
      .req_first_seat  (req_first_seat),
      .req_last_seat   (req_last_seat),
      .req_lookup_seat (req_lookup_seat),
      .req_owner_id    (req_owner_id),
      .push            (push),
      .push_item       (push_item),
      .queue_full      (queue_full)
   );

   irt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   irt_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_owner (rsp_found_owner)
   );

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = irt_pkg::DEF_ENTRIES;
   localparam int ROWS = irt_pkg::DEF_ROWS;
   localparam int SEAT_BITS = irt_pkg::DEF_SEAT_BITS;
   localparam int ROW_W = irt_pkg::ROW_W;
   localparam int SEAT_W = irt_pkg::SEAT_W;
   localparam int OWNER_W = irt_pkg::OWNER_W;
   localparam int STATUS_W = irt_pkg::STATUS_W;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES = 1200;
   localparam logic [SEAT_W-1:0] SEAT_KEEP = {SEAT_W{1'b1}} >> (SEAT_W - SEAT_BITS);
   localparam logic [8*ROW_W-1:0] ROW_POOL = {16'h0000, 16'h0001, 16'h00FF, 16'h1234,
                                              16'h8000, 16'hA5A5, 16'hFFFE, 16'hFFFF};

   typedef struct packed {
      irt_pkg::cmd_type    cmd;
      logic [ROW_W-1:0]    row;
      logic [SEAT_W-1:0]   first;
      logic [SEAT_W-1:0]   last;
      logic [SEAT_W-1:0]   seat;
      logic [OWNER_W-1:0]  owner;
   } seat_request_type;

   typedef struct packed {
      irt_pkg::status_type status;
      logic [OWNER_W-1:0]  owner;
   } answer_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = 1'b0;
   logic [ROW_W-1:0]      req_row = '0;
   logic [SEAT_W-1:0]     req_first_seat = '0;
   logic [SEAT_W-1:0]     req_last_seat = '0;
   logic [SEAT_W-1:0]     req_lookup_seat = '0;
   logic [OWNER_W-1:0]    req_owner_id = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [OWNER_W-1:0]    rsp_found_owner;

   irt_pkg::entry_type    booked [ENTRIES];
   int                    booked_count = 0;
   seat_request_type      pending_requests [$];
   answer_type            awaited_answers [$];
   seat_request_type      on_offer = '0;
   int                    send_gap = 0;
   int                    stall_left = 0;
   int                    accepted_requests = 0;
   int                    checked_answers = 0;
   int                    mismatches = 0;
   int                    idle_cycles = 0;
   logic                  hold_results = 1'b0;

   interval_reservation_table #(
      .ENTRIES(ENTRIES),
      .ROWS(ROWS),
      .SEAT_BITS(SEAT_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_row(req_row),
      .req_first_seat(req_first_seat),
      .req_last_seat(req_last_seat),
      .req_lookup_seat(req_lookup_seat),
      .req_owner_id(req_owner_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_owner(rsp_found_owner)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic answer_type settle_request(input seat_request_type r);
      answer_type a;
      logic [SEAT_W-1:0] lo, hi, seat;
      int n;
      lo = r.first & SEAT_KEEP;
      hi = r.last & SEAT_KEEP;
      seat = r.seat & SEAT_KEEP;
      n = (booked_count > ENTRIES) ? ENTRIES : booked_count;
      a.status = irt_pkg::ST_NONE;
      a.owner = '0;
      if (r.cmd == irt_pkg::CMD_RESERVE) begin
         if (int'(r.row) >= ROWS) begin
            a.status = irt_pkg::ST_OVERLAP;
         end else begin
            a.status = irt_pkg::ST_RESERVED;
            for (int i = 0; i < n; i++) begin
               if (a.status == irt_pkg::ST_RESERVED && booked[i].row == r.row &&
                   !(booked[i].last < lo || hi < booked[i].first)) begin
                  a.status = irt_pkg::ST_OVERLAP;
               end
            end
            if (a.status == irt_pkg::ST_RESERVED) begin
               if (n >= ENTRIES) begin
                  a.status = irt_pkg::ST_FULL;
               end else begin
                  booked[n] = '{row: r.row, first: lo, last: hi, owner: r.owner};
                  booked_count = n + 1;
               end
            end
         end
      end else if (int'(r.row) < ROWS) begin
         for (int i = 0; i < n; i++) begin
            if (a.status == irt_pkg::ST_NONE && booked[i].row == r.row &&
                booked[i].first <= seat && seat <= booked[i].last) begin
               a.status = irt_pkg::ST_FOUND;
               a.owner = booked[i].owner;
            end
         end
      end
      return a;
   endfunction

   function automatic seat_request_type request_of(input irt_pkg::cmd_type cmd,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [SEAT_W-1:0] first,
                                                   input logic [SEAT_W-1:0] last,
                                                   input logic [SEAT_W-1:0] seat,
                                                   input logic [OWNER_W-1:0] owner);
      seat_request_type r;
      r.cmd = cmd;
      r.row = row;
      r.first = first;
      r.last = last;
      r.seat = seat;
      r.owner = owner;
      return r;
   endfunction

   function automatic seat_request_type draw_request();
      seat_request_type r;
      int slot, roll, span;
      logic [SEAT_W-1:0] base, lo, hi;
      slot = $urandom_range(0, 7);
      roll = $urandom_range(0, 99);
      base = (slot < 4) ? '0 : ~SEAT_W'(1023);
      lo = base + SEAT_W'($urandom_range(0, 1023));
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 200) : $urandom_range(0, 15);
      hi = (lo > ~SEAT_W'(span)) ? '1 : lo + SEAT_W'(span);
      r.cmd = ($urandom_range(0, 99) < 45) ? irt_pkg::CMD_RESERVE : irt_pkg::CMD_LOOKUP;
      r.row = ROW_POOL[slot*ROW_W +: ROW_W];
      r.first = lo;
      r.last = hi;
      r.seat = base + SEAT_W'($urandom_range(0, 1023));
      r.owner = OWNER_W'($urandom);
      if (roll < 10) begin
         r.first = hi;
         r.last = lo;
      end else if (roll < 15) begin
         r.row = ROW_W'($urandom);
         r.first = SEAT_W'($urandom);
         r.last = SEAT_W'($urandom);
         r.seat = SEAT_W'($urandom);
      end
      return r;
   endfunction

   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at answer %0d: %s", checked_answers, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : drive_requests
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_answers.push_back(settle_request(on_offer));
            accepted_requests++;
            offer = 1'b0;
            send_gap = pick_gap((accepted_requests / 160) % 4 == 2);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               on_offer = pending_requests.pop_front();
               offer = 1'b1;
            end
         end
      end
      req_valid <= offer;
      req_command <= on_offer.cmd;
      req_row <= on_offer.row;
      req_first_seat <= on_offer.first;
      req_last_seat <= on_offer.last;
      req_lookup_seat <= on_offer.seat;
      req_owner_id <= on_offer.owner;
   end

   always @(posedge clock) begin : pace_answers
      if (reset) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = pick_gap((checked_answers / 160) % 4 == 3);
      end
      rsp_stall <= !reset && (hold_results || stall_left > 0);
   end

   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch($sformatf("status %0d with no request outstanding", rsp_status));
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d (%s)", rsp_status, want.status,
                                         want.status.name()));
            end
            if (rsp_found_owner !== want.owner) begin
               report_mismatch($sformatf("found_owner 0x%04h, want 0x%04h", rsp_found_owner,
                                         want.owner));
            end
         end
         checked_answers++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : hold_off_answers
      while (accepted_requests < 60) @(posedge clock);
      hold_results <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_results <= 1'b0;
   end

   initial begin : run_regression
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0000, 20'h0, 20'h0,
                                            20'h0, 16'h0000));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'hFFFF, 20'hFFFFF,
                                            20'hFFFFF, 20'h0, 16'hFFFF));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0000, 20'hFFFFF, 20'h0,
                                            20'h0, 16'hFFFF));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'hFFFF, 20'h0, 20'h0,
                                            20'hFFFFF, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'hFFFF, 20'h0, 20'h0,
                                            20'h0, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0001, 20'h0, 20'h0,
                                            20'h0, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0000, 20'h0, 20'd10,
                                            20'h0, 16'h0001));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0000, 20'd1, 20'd5,
                                            20'h0, 16'h1234));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0000, 20'd5, 20'd5,
                                            20'h0, 16'h0002));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0000, 20'd6, 20'hFFFFF,
                                            20'h0, 16'hBEEF));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0000, 20'h0, 20'h0,
                                            20'd5, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0000, 20'h0, 20'h0,
                                            20'h80000, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0001, 20'd100, 20'd50,
                                            20'h0, 16'h0F0F));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0001, 20'h0, 20'h0,
                                            20'd75, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0001, 20'h0, 20'h0,
                                            20'd100, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0001, 20'h0, 20'h0,
                                            20'd50, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0001, 20'd60, 20'd70,
                                            20'h0, 16'h0003));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0001, 20'd40, 20'd45,
                                            20'h0, 16'h0004));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0001, 20'd40, 20'd120,
                                            20'h0, 16'h0005));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'h0001, 20'd45, 20'd45,
                                            20'h0, 16'h0006));
      pending_requests.push_back(request_of(irt_pkg::CMD_RESERVE, 16'hFFFF, 20'h0, 20'hFFFFE,
                                            20'h0, 16'h5A5A));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'hFFFF, 20'h0, 20'h0,
                                            20'hFFFFE, 16'h0));
      pending_requests.push_back(request_of(irt_pkg::CMD_LOOKUP, 16'h0001, 20'h0, 20'h0,
                                            20'd65, 16'h0));
      repeat (RANDOM_REQUESTS) pending_requests.push_back(draw_request());

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() > 0 || req_valid || awaited_answers.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/irt_pkg.sv
design/irt_front.sv
design/irt_queue.sv
design/irt_back.sv
design/interval_reservation_table.sv
verif/testbench.sv
